[hdl/cacs_pkg.sv]
// shared types and constants for the cave automaton step unit
`default_nettype none

package cacs_pkg;

  // grid geometry
  localparam int ROW_W    = 64;
  localparam int WIDTH_W  = 7;
  localparam int LIMIT_W  = 4;
  localparam int COUNT_W  = 4;

  // configuration port
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 7;

  localparam logic [CFG_IDX_W-1:0] CFG_DEATH_LIMIT = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_BIRTH_LIMIT = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_GRID_WIDTH  = 2'd2;

  localparam logic [LIMIT_W-1:0] DEATH_LIMIT_RST = 4'd4;
  localparam logic [LIMIT_W-1:0] BIRTH_LIMIT_RST = 4'd4;
  localparam logic [WIDTH_W-1:0] GRID_WIDTH_RST  = 7'd50;

  // rows held by the cell chain
  typedef enum logic [1:0] {
    ST_EMPTY,
    ST_ONE,
    ST_TWO,
    ST_FLUSH
  } cacs_state_t;

  // row selection for one generation step, common to all cells
  typedef struct packed {
    logic adv;
    logic above_border;
    logic center_in;
    logic below_border;
  } cacs_ctrl_t;

  // bordered cells of one column handed to the neighbors
  typedef struct packed {
    logic a;
    logic c;
    logic b;
  } cacs_col_t;

endpackage

`default_nettype wire

[hdl/cacs_cell.sv]
// one column of the automaton: held rows and next-generation rule
`default_nettype none

module cacs_cell (
  input  wire logic                             clk,
  input  wire cacs_pkg::cacs_ctrl_t             ctrl,
  input  wire logic                             col_used,
  input  wire logic                             in_bit,
  input  wire logic [cacs_pkg::LIMIT_W-1:0]     death_limit,
  input  wire logic [cacs_pkg::LIMIT_W-1:0]     birth_limit,
  input  wire cacs_pkg::cacs_col_t              left_col,
  input  wire cacs_pkg::cacs_col_t              right_col,
  output cacs_pkg::cacs_col_t                   own_col,
  output logic                                  next_bit
);

  logic                             above_r;
  logic                             center_r;
  logic [cacs_pkg::COUNT_W-1:0]     count;
  logic                             live_next;

  // rows shift down by one on each accepted input row
  always_ff @(posedge clk) begin
    if (ctrl.adv) begin
      above_r  <= center_r;
      center_r <= in_bit;
    end
  end

  // bordered view of this column; unused columns read as alive
  always_comb begin
    own_col.a = ctrl.above_border | ~col_used | above_r;
    own_col.c = ~col_used | (ctrl.center_in ? in_bit : center_r);
    own_col.b = ctrl.below_border | ~col_used | in_bit;
  end

  // neighbor count and survival / birth rule
  always_comb begin
    count = cacs_pkg::COUNT_W'(left_col.a) + cacs_pkg::COUNT_W'(left_col.c)
          + cacs_pkg::COUNT_W'(left_col.b) + cacs_pkg::COUNT_W'(own_col.a)
          + cacs_pkg::COUNT_W'(own_col.b) + cacs_pkg::COUNT_W'(right_col.a)
          + cacs_pkg::COUNT_W'(right_col.c) + cacs_pkg::COUNT_W'(right_col.b);
    if (own_col.c) begin
      live_next = (count >= death_limit);
    end else begin
      live_next = (count > birth_limit);
    end
    next_bit = live_next & col_used;
  end

endmodule

`default_nettype wire

[hdl/cacs_out_fifo.sv]
// two-entry result queue in front of the output channel
`default_nettype none

module cacs_out_fifo (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire logic                          push,
  input  wire logic [cacs_pkg::ROW_W-1:0]    push_row,
  input  wire logic                          push_last,
  output logic                               room,
  output logic                               out_tvalid,
  input  wire logic                          out_tready,
  output logic [cacs_pkg::ROW_W-1:0]         out_tdata,   // [63:0] next_row_cells
  output logic                               out_tlast    // final_out
);

  logic [cacs_pkg::ROW_W-1:0] row_r  [2];
  logic                       last_r [2];
  logic                       wr_ptr_r;
  logic                       wr_ptr_nxt;
  logic                       rd_ptr_r;
  logic                       rd_ptr_nxt;
  logic [1:0]                 count_r;
  logic [1:0]                 count_nxt;
  logic                       pop;

  assign pop        = out_tvalid & out_tready;
  assign room       = (count_r != 2'd2);
  assign out_tvalid = (count_r != 2'd0);
  assign out_tdata  = row_r[rd_ptr_r];
  assign out_tlast  = last_r[rd_ptr_r];

  // pointer and fill bookkeeping
  always_comb begin
    wr_ptr_nxt = push ? ~wr_ptr_r : wr_ptr_r;
    rd_ptr_nxt = pop ? ~rd_ptr_r : rd_ptr_r;
    count_nxt  = count_r + 2'(push) - 2'(pop);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      count_r  <= 2'd0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  // entry storage
  always_ff @(posedge clk) begin
    if (push) begin
      row_r[wr_ptr_r]  <= push_row;
      last_r[wr_ptr_r] <= push_last;
    end
  end

endmodule

`default_nettype wire

[hdl/cellular_automaton_cave_step_unit.sv]
// top level: cave automaton generation step over a chain of column cells
//
//  channel | direction | handshake            | payload
//  in_     | slave     | in_tvalid/in_tready   | tdata row_cells, tlast final_row
//  out_    | master    | out_tvalid/out_tready | tdata next_row_cells, tlast final_out
//  cfg_    | slave     | cfg_valid/cfg_ready   | cfg_index, cfg_data
//
// one row per cycle while the result queue has room; a row result leaves one row behind its input row.
// a final row that follows held rows adds a flush step: the chain of 64
// column cells computes the last result from its held rows while the input is held off.
// results pass through a two-entry queue, so up to two rows wait on a stall.
// synchronous active-low reset empties the row chain and the queue and
// loads the limits 4 / 4 and width 50; configuration is always ready.
`default_nettype none

module cellular_automaton_cave_step_unit (
  input  wire logic                               clk,
  input  wire logic                               rst_n,
  input  wire logic                               in_tvalid,
  output logic                                    in_tready,
  input  wire logic [cacs_pkg::ROW_W-1:0]         in_tdata,    // [63:0] row_cells
  input  wire logic                               in_tlast,    // final_row
  output logic                                    out_tvalid,
  input  wire logic                               out_tready,
  output logic [cacs_pkg::ROW_W-1:0]              out_tdata,   // [63:0] next_row_cells
  output logic                                    out_tlast,   // final_out
  input  wire logic                               cfg_valid,
  output logic                                    cfg_ready,
  input  wire logic [cacs_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  wire logic [cacs_pkg::CFG_DATA_W-1:0]    cfg_data
);

  logic [cacs_pkg::LIMIT_W-1:0]   death_limit_r;
  logic [cacs_pkg::LIMIT_W-1:0]   birth_limit_r;
  logic [cacs_pkg::WIDTH_W-1:0]   grid_width_r;
  cacs_pkg::cacs_state_t          state_r;
  cacs_pkg::cacs_state_t          state_nxt;
  cacs_pkg::cacs_ctrl_t           ctrl;
  cacs_pkg::cacs_col_t            cols [cacs_pkg::ROW_W];
  logic [cacs_pkg::ROW_W-1:0]     col_used;
  logic [cacs_pkg::ROW_W-1:0]     res_row;
  logic                           res_push;
  logic                           res_last;
  logic                           room;
  logic                           in_req;

  // configuration registers
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      death_limit_r <= cacs_pkg::DEATH_LIMIT_RST;
      birth_limit_r <= cacs_pkg::BIRTH_LIMIT_RST;
      grid_width_r  <= cacs_pkg::GRID_WIDTH_RST;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        cacs_pkg::CFG_DEATH_LIMIT: death_limit_r <= cfg_data[cacs_pkg::LIMIT_W-1:0];
        cacs_pkg::CFG_BIRTH_LIMIT: birth_limit_r <= cfg_data[cacs_pkg::LIMIT_W-1:0];
        cacs_pkg::CFG_GRID_WIDTH:  grid_width_r  <= cfg_data;
        default: ;
      endcase
    end
  end

  assign in_req = in_tvalid & in_tready;

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      cacs_pkg::ST_EMPTY: begin
        if (in_req) begin
          state_nxt = in_tlast ? cacs_pkg::ST_EMPTY : cacs_pkg::ST_ONE;
        end
      end
      cacs_pkg::ST_ONE, cacs_pkg::ST_TWO: begin
        if (in_req) begin
          state_nxt = in_tlast ? cacs_pkg::ST_FLUSH : cacs_pkg::ST_TWO;
        end
      end
      cacs_pkg::ST_FLUSH: begin
        if (room) begin
          state_nxt = cacs_pkg::ST_EMPTY;
        end
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= cacs_pkg::ST_EMPTY;
    end else begin
      state_r <= state_nxt;
    end
  end

  // outputs of the sequencer: row selection, handshake and queue push
  always_comb begin
    in_tready         = room;
    ctrl.adv          = 1'b0;
    ctrl.above_border = 1'b0;
    ctrl.center_in    = 1'b0;
    ctrl.below_border = 1'b0;
    res_push          = 1'b0;
    res_last          = 1'b0;
    unique case (state_r)
      cacs_pkg::ST_EMPTY: begin
        ctrl.adv          = in_req;
        ctrl.above_border = 1'b1;
        ctrl.center_in    = 1'b1;
        ctrl.below_border = 1'b1;
        res_push          = in_req & in_tlast;
        res_last          = 1'b1;
      end
      cacs_pkg::ST_ONE: begin
        ctrl.adv          = in_req;
        ctrl.above_border = 1'b1;
        res_push          = in_req;
      end
      cacs_pkg::ST_TWO: begin
        ctrl.adv          = in_req;
        res_push          = in_req;
      end
      cacs_pkg::ST_FLUSH: begin
        in_tready         = 1'b0;
        ctrl.below_border = 1'b1;
        res_push          = room;
        res_last          = 1'b1;
      end
    endcase
  end

  // chain of column cells, alive border beyond both ends
  for (genvar k = 0; k < cacs_pkg::ROW_W; k++) begin : g_col
    cacs_pkg::cacs_col_t left_col;
    cacs_pkg::cacs_col_t right_col;

    assign col_used[k] = (cacs_pkg::WIDTH_W'(k) < grid_width_r);

    if (k == 0) begin : g_left_edge
      assign left_col = '1;
    end else begin : g_left_nb
      assign left_col = cols[k-1];
    end

    if (k == cacs_pkg::ROW_W - 1) begin : g_right_edge
      assign right_col = '1;
    end else begin : g_right_nb
      assign right_col = cols[k+1];
    end

    cacs_cell u_cell (
      .clk         (clk),
      .ctrl        (ctrl),
      .col_used    (col_used[k]),
      .in_bit      (in_tdata[k]),
      .death_limit (death_limit_r),
      .birth_limit (birth_limit_r),
      .left_col    (left_col),
      .right_col   (right_col),
      .own_col     (cols[k]),
      .next_bit    (res_row[k])
    );
  end

  // result queue toward the output channel
  cacs_out_fifo u_out_fifo (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (res_push),
    .push_row   (res_row),
    .push_last  (res_last),
    .room       (room),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast)
  );

`ifndef SYNTH
  // a result is only produced when the queue can take it
  a_push_room: assert property (@(posedge clk) disable iff (!rst_n)
    res_push |-> room)
    else $error("result pushed into a full queue");

  // a final row after held rows leads to the flush cycle
  a_final_flush: assert property (@(posedge clk) disable iff (!rst_n)
    (in_req && in_tlast && (state_r == cacs_pkg::ST_ONE || state_r == cacs_pkg::ST_TWO))
    |=> (state_r == cacs_pkg::ST_FLUSH))
    else $error("final row did not start the flush");

  // a blocked flush keeps its place and holds off the input
  a_flush_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == cacs_pkg::ST_FLUSH && !room) |=> (state_r == cacs_pkg::ST_FLUSH && !in_tready))
    else $error("flush lost while the queue was full");
`endif

endmodule

`default_nettype wire

[test/cellular_automaton_cave_step_unit_tb.sv]
// self-checking testbench for the cave automaton generation step unit
`timescale 1ns / 100ps

module cellular_automaton_cave_step_unit_tb;

  localparam int ROWS_TARGET   = 1800;
  localparam int SETTLE_CYCLES = 6;
  localparam logic [cacs_pkg::ROW_W-1:0] ALL_ALIVE = '1;
  localparam logic [cacs_pkg::ROW_W-1:0] BAND_50   = 64'h0003_FFFF_FFFF_FFFF;
  // index with no register behind it, writes there change nothing
  localparam logic [cacs_pkg::CFG_IDX_W-1:0] CFG_UNUSED = 2'd3;

  typedef enum logic {OP_ROW, OP_CFG} plan_op_t;

  // one line of the directed plan: a grid row or a register write
  typedef struct packed {
    plan_op_t                             op;
    logic [cacs_pkg::ROW_W-1:0]           cells;
    logic                                 last;
    logic [cacs_pkg::CFG_IDX_W-1:0]       idx;
    logic [cacs_pkg::CFG_DATA_W-1:0]      val;
    logic                                 pinned;
    logic [cacs_pkg::ROW_W-1:0]           pin;
  } plan_step_t;

  typedef struct packed {
    logic [cacs_pkg::ROW_W-1:0] cells;
    logic                       last;
  } gen_row_t;

  logic                                 clk = 1'b0;
  logic                                 rst_n = 1'b0;
  logic                                 in_tvalid = 1'b0;
  logic                                 in_tready;
  logic [cacs_pkg::ROW_W-1:0]           in_tdata = '0;   // [63:0] row_cells
  logic                                 in_tlast = 1'b0; // final_row
  logic                                 out_tvalid;
  logic                                 out_tready = 1'b0;
  logic [cacs_pkg::ROW_W-1:0]           out_tdata;       // [63:0] next_row_cells
  logic                                 out_tlast;       // final_out
  logic                                 cfg_valid = 1'b0;
  logic                                 cfg_ready;
  logic [cacs_pkg::CFG_IDX_W-1:0]       cfg_index = '0;
  logic [cacs_pkg::CFG_DATA_W-1:0]      cfg_data = '0;

  // hand-worked result travelling with a single-row grid request
  logic                                 pin_valid = 1'b0;
  logic [cacs_pkg::ROW_W-1:0]           pin_cells = '0;

  // generation predictor state
  logic [cacs_pkg::LIMIT_W-1:0]         model_death = cacs_pkg::DEATH_LIMIT_RST;
  logic [cacs_pkg::LIMIT_W-1:0]         model_birth = cacs_pkg::BIRTH_LIMIT_RST;
  logic [cacs_pkg::WIDTH_W-1:0]         model_width = cacs_pkg::GRID_WIDTH_RST;
  logic [cacs_pkg::ROW_W-1:0]           held_above = '0;
  logic [cacs_pkg::ROW_W-1:0]           held_center = '0;
  int                                   held_rows = 0;
  gen_row_t                             next_gen_q[$];

  int errors = 0;
  int rows_sent = 0;
  int grids_taken = 0;
  int results_seen = 0;
  int reg_writes = 0;
  int tx_mode = 1;
  int rx_mode = 1;
  int rx_hold_cnt = 0;

  plan_step_t plan[$];

  cellular_automaton_cave_step_unit DUT (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tlast   (in_tlast),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data)
  );

  initial begin
    forever #2 clk = ~clk;
  end

  // columns in use, width saturates at the row size
  function automatic logic [cacs_pkg::ROW_W-1:0] column_mask(
      input logic [cacs_pkg::WIDTH_W-1:0] w);
    if (w >= cacs_pkg::ROW_W) return '1;
    return (64'd1 << w) - 64'd1;
  endfunction

  // columns outside the grid read as alive
  function automatic logic [cacs_pkg::ROW_W-1:0] bordered(
      input logic [cacs_pkg::ROW_W-1:0] r,
      input logic [cacs_pkg::ROW_W-1:0] mask);
    return (r & mask) | ~mask;
  endfunction

  // next generation of center row c, with a above and b below
  function automatic logic [cacs_pkg::ROW_W-1:0] evolve_row(
      input logic [cacs_pkg::ROW_W-1:0] a,
      input logic [cacs_pkg::ROW_W-1:0] c,
      input logic [cacs_pkg::ROW_W-1:0] b,
      input logic [cacs_pkg::ROW_W-1:0] mask);
    logic [cacs_pkg::ROW_W-1:0] res;
    logic [cacs_pkg::ROW_W+1:0] ax, cx, bx;
    int n;
    res = '0;
    // pad both ends with the alive border, bit k+1 is column k
    ax = {1'b1, a, 1'b1};
    cx = {1'b1, c, 1'b1};
    bx = {1'b1, b, 1'b1};
    for (int k = 0; k < cacs_pkg::ROW_W; k++) begin
      n = ax[k] + ax[k+1] + ax[k+2] + cx[k] + cx[k+2] + bx[k] + bx[k+1] + bx[k+2];
      if (cx[k+1]) res[k] = (n >= model_death);
      else res[k] = (n > model_birth);
    end
    return res & mask;
  endfunction

  // take one input row, queue the result rows it releases
  function automatic void advance_generation(input logic [cacs_pkg::ROW_W-1:0] row,
                                             input logic last,
                                             input logic pinned,
                                             input logic [cacs_pkg::ROW_W-1:0] pin);
    logic [cacs_pkg::ROW_W-1:0] mask, above;
    gen_row_t res;
    mask = column_mask(model_width);
    if (held_rows == 0) begin
      if (last) begin
        // single-row grid: border above and below
        res.cells = pinned ? pin
                           : evolve_row(ALL_ALIVE, bordered(row, mask), ALL_ALIVE, mask);
        res.last = 1'b1;
        next_gen_q.push_back(res);
      end else begin
        held_center = row;
        held_rows = 1;
      end
    end else begin
      above = (held_rows == 1) ? ALL_ALIVE : bordered(held_above, mask);
      res.cells = evolve_row(above, bordered(held_center, mask), bordered(row, mask), mask);
      res.last = 1'b0;
      next_gen_q.push_back(res);
      held_above = held_center;
      held_center = row;
      held_rows = 2;
      // final row flushes itself against the bottom border
      if (last) begin
        res.cells = evolve_row(bordered(held_above, mask), bordered(held_center, mask),
                               ALL_ALIVE, mask);
        res.last = 1'b1;
        next_gen_q.push_back(res);
        held_above = '0;
        held_center = '0;
        held_rows = 0;
      end
    end
  endfunction

  // idle length: mostly none or short, now and then long
  function automatic int pause_len(input int mode);
    int r;
    if (mode == 0) return 0;
    r = $urandom_range(0, 99);
    if (r < 65) return 0;
    if (r < 93) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  function automatic logic [cacs_pkg::ROW_W-1:0] random_row();
    logic [cacs_pkg::ROW_W-1:0] r;
    r = {$urandom, $urandom};
    case ($urandom_range(0, 9))
      0: r = r & {$urandom, $urandom} & {$urandom, $urandom};
      1: r = r | {$urandom, $urandom};
      2: r = '0;
      3: r = '1;
      default: ;
    endcase
    return r;
  endfunction

  // register values mostly in the useful range, sometimes any code
  function automatic logic [cacs_pkg::CFG_DATA_W-1:0] random_reg_value(
      input logic [cacs_pkg::CFG_IDX_W-1:0] idx);
    if ($urandom_range(0, 7) == 0) return cacs_pkg::CFG_DATA_W'($urandom);
    case (idx)
      cacs_pkg::CFG_DEATH_LIMIT: return cacs_pkg::CFG_DATA_W'($urandom_range(0, 9));
      cacs_pkg::CFG_BIRTH_LIMIT: return cacs_pkg::CFG_DATA_W'($urandom_range(0, 8));
      default: begin
        if ($urandom_range(0, 3) == 0) return cacs_pkg::CFG_DATA_W'(cacs_pkg::ROW_W);
        if ($urandom_range(0, 2) == 0) return cacs_pkg::CFG_DATA_W'($urandom_range(1, 8));
        return cacs_pkg::CFG_DATA_W'($urandom_range(1, cacs_pkg::ROW_W));
      end
    endcase
  endfunction

  function automatic void plan_row(input logic [cacs_pkg::ROW_W-1:0] cells, input logic last,
                                   input logic pinned, input logic [cacs_pkg::ROW_W-1:0] pin);
    plan_step_t s;
    s = '0;
    s.op = OP_ROW;
    s.cells = cells;
    s.last = last;
    s.pinned = pinned;
    s.pin = pin;
    plan.push_back(s);
  endfunction

  function automatic void plan_cfg(input logic [cacs_pkg::CFG_IDX_W-1:0] idx,
                                   input logic [cacs_pkg::CFG_DATA_W-1:0] val);
    plan_step_t s;
    s = '0;
    s.op = OP_CFG;
    s.idx = idx;
    s.val = val;
    plan.push_back(s);
  endfunction

  // row request, holds valid until taken
  task automatic send_row(input logic [cacs_pkg::ROW_W-1:0] cells, input logic last,
                          input logic pinned, input logic [cacs_pkg::ROW_W-1:0] pin);
    int gap;
    gap = pause_len(tx_mode);
    cfg_valid <= 1'b0;
    if (gap > 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata <= cells;
    in_tlast <= last;
    pin_valid <= pinned;
    pin_cells <= pin;
    do @(posedge clk); while (!in_tready);
    rows_sent++;
  endtask

  // register write request
  task automatic write_reg(input logic [cacs_pkg::CFG_IDX_W-1:0] idx,
                           input logic [cacs_pkg::CFG_DATA_W-1:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    do @(posedge clk); while (!cfg_ready);
    reg_writes++;
  endtask

  // wait for every pending result, then let the block settle
  task automatic drain_rows();
    in_tvalid <= 1'b0;
    do @(posedge clk); while (next_gen_q.size() != 0);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // result side backpressure
  always @(posedge clk) begin
    int s;
    if (rx_hold_cnt > 0) begin
      out_tready <= 1'b0;
      rx_hold_cnt = rx_hold_cnt - 1;
    end else begin
      s = pause_len(rx_mode);
      out_tready <= (s == 0);
      if (s > 0) rx_hold_cnt = s - 1;
    end
  end

  // predictor update on accepted requests, compare on accepted results
  always @(posedge clk) begin
    gen_row_t want;
    if (rst_n) begin
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          cacs_pkg::CFG_DEATH_LIMIT: model_death = cfg_data[cacs_pkg::LIMIT_W-1:0];
          cacs_pkg::CFG_BIRTH_LIMIT: model_birth = cfg_data[cacs_pkg::LIMIT_W-1:0];
          cacs_pkg::CFG_GRID_WIDTH:  model_width = cfg_data[cacs_pkg::WIDTH_W-1:0];
          default: ;
        endcase
      end
      if (in_tvalid && in_tready) begin
        advance_generation(in_tdata, in_tlast, pin_valid, pin_cells);
        if (in_tlast) grids_taken++;
      end
      if (out_tvalid && out_tready) begin
        if (next_gen_q.size() == 0) begin
          $error("result row %h with nothing expected", out_tdata);
          errors++;
        end else begin
          want = next_gen_q.pop_front();
          results_seen++;
          if (out_tdata !== want.cells) begin
            $error("next_row_cells: expected %h, got %h", want.cells, out_tdata);
            errors++;
          end
          if (out_tlast !== want.last) begin
            $error("final_out: expected %b, got %b", want.last, out_tlast);
            errors++;
          end
        end
      end
    end
  end

  // run limit
  initial begin
    #4_000_000;
    $display("cellular_automaton_cave_step_unit: mismatch");
    $finish;
  end

  // stimulus
  initial begin
    plan_step_t step;
    plan_op_t prev_op;
    logic [cacs_pkg::CFG_IDX_W-1:0] idx;
    int n_writes, n_grids, height, r;

    // defaults after reset: all-alive and all-dead single rows both fill the band
    plan_row(ALL_ALIVE, 1'b1, 1'b1, BAND_50);
    plan_row('0, 1'b1, 1'b1, BAND_50);
    plan_row('0, 1'b0, 1'b0, '0);
    plan_row(ALL_ALIVE, 1'b0, 1'b0, '0);
    plan_row(64'h5555_5555_5555_5555, 1'b1, 1'b0, '0);
    // full row width
    plan_cfg(cacs_pkg::CFG_GRID_WIDTH, 7'd64);
    plan_row(ALL_ALIVE, 1'b0, 1'b0, '0);
    plan_row(ALL_ALIVE, 1'b1, 1'b0, '0);
    plan_row(64'h0000_0001_8000_0000, 1'b0, 1'b0, '0);
    plan_row(64'h8000_0000_0000_0001, 1'b0, 1'b0, '0);
    plan_row('0, 1'b0, 1'b0, '0);
    plan_row(64'h00FF_00FF_00FF_00FF, 1'b1, 1'b0, '0);
    // zero width: everything is border, result empty
    plan_cfg(cacs_pkg::CFG_GRID_WIDTH, 7'd0);
    plan_row(64'hDEAD_BEEF_0BAD_F00D, 1'b1, 1'b1, '0);
    // oversized width saturates
    plan_cfg(cacs_pkg::CFG_GRID_WIDTH, 7'd127);
    plan_row(ALL_ALIVE, 1'b0, 1'b0, '0);
    plan_row('0, 1'b0, 1'b0, '0);
    plan_row(64'hAAAA_AAAA_AAAA_AAAA, 1'b1, 1'b0, '0);
    // out-of-range limits: no survivor, no birth
    plan_cfg(cacs_pkg::CFG_DEATH_LIMIT, 7'd127);
    plan_cfg(cacs_pkg::CFG_BIRTH_LIMIT, 7'd127);
    plan_row(ALL_ALIVE, 1'b1, 1'b1, '0);
    plan_row('0, 1'b1, 1'b1, '0);
    // zero limits on a one-column grid: always alive
    plan_cfg(cacs_pkg::CFG_DEATH_LIMIT, 7'd0);
    plan_cfg(cacs_pkg::CFG_BIRTH_LIMIT, 7'd0);
    plan_cfg(cacs_pkg::CFG_GRID_WIDTH, 7'd1);
    plan_row('0, 1'b1, 1'b1, 64'd1);
    plan_row(ALL_ALIVE, 1'b1, 1'b1, 64'd1);
    // top of the documented limit ranges, plus a write to the spare index
    plan_cfg(cacs_pkg::CFG_DEATH_LIMIT, 7'd9);
    plan_cfg(cacs_pkg::CFG_BIRTH_LIMIT, 7'd8);
    plan_cfg(CFG_UNUSED, 7'h55);
    plan_row(ALL_ALIVE, 1'b0, 1'b0, '0);
    plan_row(ALL_ALIVE, 1'b1, 1'b0, '0);
    // narrow three-column width, input bits past it ignored
    plan_cfg(cacs_pkg::CFG_DEATH_LIMIT, 7'd4);
    plan_cfg(cacs_pkg::CFG_BIRTH_LIMIT, 7'd4);
    plan_cfg(cacs_pkg::CFG_GRID_WIDTH, 7'd3);
    plan_row(64'h5, 1'b0, 1'b0, '0);
    plan_row(64'h2, 1'b0, 1'b0, '0);
    plan_row(64'hFFFF_FFFF_FFFF_FFF8, 1'b1, 1'b0, '0);

    repeat (8) @(posedge clk);
    rst_n <= 1'b1;

    // directed plan
    prev_op = OP_ROW;
    foreach (plan[i]) begin
      step = plan[i];
      if (step.op == OP_CFG) begin
        if (prev_op == OP_ROW) drain_rows();
        write_reg(step.idx, step.val);
      end else begin
        send_row(step.cells, step.last, step.pinned, step.pin);
      end
      prev_op = step.op;
    end

    // random phases of whole grids under changing settings
    while (rows_sent < ROWS_TARGET) begin
      drain_rows();
      n_writes = $urandom_range(1, 3);
      repeat (n_writes) begin
        r = $urandom_range(0, 15);
        idx = (r == 0) ? CFG_UNUSED : (r < 6) ? cacs_pkg::CFG_DEATH_LIMIT :
              (r < 11) ? cacs_pkg::CFG_BIRTH_LIMIT : cacs_pkg::CFG_GRID_WIDTH;
        write_reg(idx, random_reg_value(idx));
      end
      tx_mode = ($urandom_range(0, 4) == 0) ? 0 : 1;
      rx_mode = ($urandom_range(0, 4) == 0) ? 0 : 1;
      n_grids = $urandom_range(1, 6);
      repeat (n_grids) begin
        r = $urandom_range(0, 9);
        height = (r == 0) ? 1 : (r == 1) ? 2 : $urandom_range(3, 14);
        for (int k = 0; k < height; k++)
          send_row(random_row(), k == height - 1, 1'b0, '0);
      end
    end

    drain_rows();
    $display("sent %0d rows in %0d grids with %0d register writes", rows_sent, grids_taken,
             reg_writes);
    $display("checked %0d result rows across widths, limits and idle patterns", results_seen);
    if (errors == 0)
      $display("cellular_automaton_cave_step_unit: match");
    else
      $display("cellular_automaton_cave_step_unit: mismatch");
    $finish;
  end

endmodule
